/* rtl/lrc_tsp_pkg.sv */
// ----------------------------------------------------------------------------
// LRC timestamp tag parser package
// Shared widths, character codes, status codes and the close record type.
// ----------------------------------------------------------------------------
package lrc_tsp_pkg;

   localparam int FIELD_WIDTH     = 32;
   localparam int CHAR_W          = 8;
   localparam int TIME_W          = 40;
   localparam int STATUS_W        = 2;
   localparam int LEN_W           = 5;
   localparam int COLON_W         = 2;
   localparam int FRAC_W          = 10;
   localparam int FRAC_DIGITS_W   = 2;

   localparam logic [LEN_W-1:0]         LEN_MAX         = 5'd31;
   localparam logic [LEN_W-1:0]         ANGLE_MAX_INNER = 5'd29;
   localparam logic [COLON_W-1:0]       MAX_COLONS      = 2'd2;
   localparam logic [FRAC_DIGITS_W-1:0] MAX_FRAC_DIGITS = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MALFORMED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd2;

   localparam logic [CHAR_W-1:0] CHAR_SQ_OPEN    = 8'h5B;
   localparam logic [CHAR_W-1:0] CHAR_SQ_CLOSE   = 8'h5D;
   localparam logic [CHAR_W-1:0] CHAR_ANG_OPEN   = 8'h3C;
   localparam logic [CHAR_W-1:0] CHAR_ANG_CLOSE  = 8'h3E;
   localparam logic [CHAR_W-1:0] CHAR_COLON      = 8'h3A;
   localparam logic [CHAR_W-1:0] CHAR_DOT        = 8'h2E;
   localparam logic [CHAR_W-1:0] CHAR_ZERO       = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE       = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A    = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_Z    = 8'h7A;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A    = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_Z    = 8'h5A;

   typedef struct packed {
      logic                     bad;
      logic                     overflowed;
      logic [FRAC_W-1:0]        frac_value;
      logic [FRAC_DIGITS_W-1:0] frac_digits;
   } lrc_tsp_close_type;

endpackage

/* rtl/lrc_tsp_ifs.sv */
// ----------------------------------------------------------------------------
// LRC timestamp tag parser channels
// Valid/ready channels for text bytes, results and the mode register.
// ----------------------------------------------------------------------------
interface lrc_tsp_req_if;
   logic                              valid;
   logic                              ready;
   logic [lrc_tsp_pkg::CHAR_W-1:0]    char_byte;
   logic                              line_break;

   modport source (output valid, output char_byte, output line_break, input ready);
   modport sink   (input valid, input char_byte, input line_break, output ready);
endinterface

interface lrc_tsp_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [lrc_tsp_pkg::TIME_W-1:0]    time_ms;
   logic [lrc_tsp_pkg::STATUS_W-1:0]  status;

   modport source (output valid, output time_ms, output status, input ready);
   modport sink   (input valid, input time_ms, input status, output ready);
endinterface

interface lrc_tsp_csr_if;
   logic valid;
   logic ready;
   logic data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* rtl/lrc_tsp_scanner.sv */
// ----------------------------------------------------------------------------
// LRC timestamp tag scanner
// Per-byte tag tracking, field accumulation and syntax checks; emits a
// close record when the closing byte of an open tag arrives.
// ----------------------------------------------------------------------------
module lrc_tsp_scanner #(
   parameter int FIELD_WIDTH = lrc_tsp_pkg::FIELD_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   lrc_tsp_req_if.sink                    req_chan,
   lrc_tsp_csr_if.sink                    csr_chan,
   input  logic                           rec_ready,
   output logic                           rec_valid,
   output lrc_tsp_pkg::lrc_tsp_close_type rec_info,
   output logic [FIELD_WIDTH-1:0]         rec_upper,
   output logic [FIELD_WIDTH-1:0]         rec_field
);

   localparam int UP_W = FIELD_WIDTH + 7;
   localparam int FD_W = FIELD_WIDTH + 4;

   logic                                    angle_mode_ff, angle_mode_in;
   logic                                    tag_open_ff, tag_open_in;
   logic                                    first_inner_ff, first_inner_in;
   logic [lrc_tsp_pkg::COLON_W-1:0]         colon_count_ff, colon_count_in;
   logic                                    dot_seen_ff, dot_seen_in;
   logic                                    malformed_ff, malformed_in;
   logic                                    overflowed_ff, overflowed_in;
   logic [lrc_tsp_pkg::LEN_W-1:0]           inner_length_ff, inner_length_in;
   logic [FIELD_WIDTH-1:0]                  upper_total_ff, upper_total_in;
   logic [FIELD_WIDTH-1:0]                  field_value_ff, field_value_in;
   logic [lrc_tsp_pkg::FRAC_W-1:0]          frac_value_ff, frac_value_in;
   logic [lrc_tsp_pkg::FRAC_DIGITS_W-1:0]   frac_digits_ff, frac_digits_in;

   logic                                    accept;
   logic [lrc_tsp_pkg::CHAR_W-1:0]          c;
   logic [lrc_tsp_pkg::CHAR_W-1:0]          open_c, close_c;
   logic                                    is_letter, is_digit, is_close;
   logic [3:0]                              digit;
   logic [UP_W-1:0]                         upper_sum;
   logic [FD_W-1:0]                         field_sum;
   logic [lrc_tsp_pkg::FRAC_W+3:0]          frac_sum;

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = rec_ready;
   assign accept         = req_chan.valid && rec_ready;
   assign c              = req_chan.char_byte;

   assign open_c  = angle_mode_ff ? lrc_tsp_pkg::CHAR_ANG_OPEN  : lrc_tsp_pkg::CHAR_SQ_OPEN;
   assign close_c = angle_mode_ff ? lrc_tsp_pkg::CHAR_ANG_CLOSE : lrc_tsp_pkg::CHAR_SQ_CLOSE;

   assign is_letter = (c >= lrc_tsp_pkg::CHAR_LOWER_A && c <= lrc_tsp_pkg::CHAR_LOWER_Z) ||
                      (c >= lrc_tsp_pkg::CHAR_UPPER_A && c <= lrc_tsp_pkg::CHAR_UPPER_Z);
   assign is_digit  = (c >= lrc_tsp_pkg::CHAR_ZERO) && (c <= lrc_tsp_pkg::CHAR_NINE);
   assign is_close  = tag_open_ff && !req_chan.line_break && (c == close_c);
   assign digit     = c[3:0];

   // x*60 = x*64 - x*4, x*10 = x*8 + x*2
   assign upper_sum = ({7'd0, upper_total_ff} << 6) - ({7'd0, upper_total_ff} << 2)
                    + {7'd0, field_value_ff};
   assign field_sum = ({4'd0, field_value_ff} << 3) + ({4'd0, field_value_ff} << 1)
                    + {{(FD_W-4){1'b0}}, digit[3:0]};
   assign frac_sum  = ({4'd0, frac_value_ff} << 3) + ({4'd0, frac_value_ff} << 1)
                    + {{(lrc_tsp_pkg::FRAC_W){1'b0}}, digit[3:0]};

   assign rec_valid           = accept && is_close;
   assign rec_upper           = upper_total_ff;
   assign rec_field           = field_value_ff;
   assign rec_info.bad        = malformed_ff || (colon_count_ff == '0) ||
                                (angle_mode_ff && (inner_length_ff > lrc_tsp_pkg::ANGLE_MAX_INNER));
   assign rec_info.overflowed = overflowed_ff;
   assign rec_info.frac_value = frac_value_ff;
   assign rec_info.frac_digits = frac_digits_ff;

   always_comb begin
      angle_mode_in   = angle_mode_ff;
      tag_open_in     = tag_open_ff;
      first_inner_in  = first_inner_ff;
      colon_count_in  = colon_count_ff;
      dot_seen_in     = dot_seen_ff;
      malformed_in    = malformed_ff;
      overflowed_in   = overflowed_ff;
      inner_length_in = inner_length_ff;
      upper_total_in  = upper_total_ff;
      field_value_in  = field_value_ff;
      frac_value_in   = frac_value_ff;
      frac_digits_in  = frac_digits_ff;

      if (csr_chan.valid) begin
         angle_mode_in = csr_chan.data;
      end

      if (accept) begin
         if (req_chan.line_break || is_close || (!tag_open_ff && c == open_c)) begin
            // start or end of a tag, or a line break: clear the per-tag state
            tag_open_in     = !req_chan.line_break && !tag_open_ff;
            first_inner_in  = !req_chan.line_break && !tag_open_ff;
            colon_count_in  = '0;
            dot_seen_in     = 1'b0;
            malformed_in    = 1'b0;
            overflowed_in   = 1'b0;
            inner_length_in = '0;
            upper_total_in  = '0;
            field_value_in  = '0;
            frac_value_in   = '0;
            frac_digits_in  = '0;
         end else if (tag_open_ff) begin
            if (inner_length_ff != lrc_tsp_pkg::LEN_MAX) begin
               inner_length_in = inner_length_ff + 1'b1;
            end
            if (first_inner_ff && is_letter) begin
               malformed_in = 1'b1;
            end
            first_inner_in = 1'b0;

            if (c == lrc_tsp_pkg::CHAR_COLON) begin
               if (colon_count_ff >= lrc_tsp_pkg::MAX_COLONS || dot_seen_ff) begin
                  malformed_in = 1'b1;
               end else begin
                  if (upper_sum[UP_W-1:FIELD_WIDTH] != '0) begin
                     overflowed_in  = 1'b1;
                     upper_total_in = '1;
                  end else begin
                     upper_total_in = upper_sum[FIELD_WIDTH-1:0];
                  end
                  field_value_in = '0;
                  colon_count_in = colon_count_ff + 1'b1;
               end
            end else if (c == lrc_tsp_pkg::CHAR_DOT) begin
               if (dot_seen_ff || colon_count_ff == '0) begin
                  malformed_in = 1'b1;
               end
               dot_seen_in = 1'b1;
            end else if (is_digit) begin
               if (dot_seen_ff) begin
                  if (frac_digits_ff < lrc_tsp_pkg::MAX_FRAC_DIGITS) begin
                     frac_value_in  = frac_sum[lrc_tsp_pkg::FRAC_W-1:0];
                     frac_digits_in = frac_digits_ff + 1'b1;
                  end
               end else if (field_sum[FD_W-1:FIELD_WIDTH] != '0) begin
                  overflowed_in  = 1'b1;
                  field_value_in = '1;
               end else begin
                  field_value_in = field_sum[FIELD_WIDTH-1:0];
               end
            end else begin
               malformed_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_mode_ff   <= 1'b0;
         tag_open_ff     <= 1'b0;
         first_inner_ff  <= 1'b0;
         colon_count_ff  <= '0;
         dot_seen_ff     <= 1'b0;
         malformed_ff    <= 1'b0;
         overflowed_ff   <= 1'b0;
         inner_length_ff <= '0;
         upper_total_ff  <= '0;
         field_value_ff  <= '0;
         frac_value_ff   <= '0;
         frac_digits_ff  <= '0;
      end else begin
         angle_mode_ff   <= angle_mode_in;
         tag_open_ff     <= tag_open_in;
         first_inner_ff  <= first_inner_in;
         colon_count_ff  <= colon_count_in;
         dot_seen_ff     <= dot_seen_in;
         malformed_ff    <= malformed_in;
         overflowed_ff   <= overflowed_in;
         inner_length_ff <= inner_length_in;
         upper_total_ff  <= upper_total_in;
         field_value_ff  <= field_value_in;
         frac_value_ff   <= frac_value_in;
         frac_digits_ff  <= frac_digits_in;
      end
   end

endmodule

/* rtl/lrc_tsp_calc.sv */
// ----------------------------------------------------------------------------
// LRC timestamp millisecond calculator
// Three-stage pipeline from close record to result: capture, fold to
// seconds and pad fraction, scale to milliseconds and range check.
// ----------------------------------------------------------------------------
module lrc_tsp_calc #(
   parameter int FIELD_WIDTH = lrc_tsp_pkg::FIELD_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           rec_valid,
   output logic                           rec_ready,
   input  lrc_tsp_pkg::lrc_tsp_close_type rec_info,
   input  logic [FIELD_WIDTH-1:0]         rec_upper,
   input  logic [FIELD_WIDTH-1:0]         rec_field,
   lrc_tsp_rsp_if.source                  rsp_chan
);

   localparam int CALC_W = (FIELD_WIDTH + 16 > lrc_tsp_pkg::TIME_W + 1) ?
                           FIELD_WIDTH + 16 : lrc_tsp_pkg::TIME_W + 1;
   localparam int FW = lrc_tsp_pkg::FRAC_W;

   logic                           adv1, adv2, adv3;

   logic                           v1_ff;
   lrc_tsp_pkg::lrc_tsp_close_type info1_ff;
   logic [FIELD_WIDTH-1:0]         upper1_ff;
   logic [FIELD_WIDTH-1:0]         field1_ff;

   logic                           v2_ff;
   logic                           bad2_ff, ovf2_ff;
   logic [CALC_W-1:0]              sec2_ff, sec2_in;
   logic [FW-1:0]                  frac2_ff, frac2_in;
   logic [FW+3:0]                  frac_wide;

   logic                           v3_ff;
   logic [lrc_tsp_pkg::TIME_W-1:0] time3_ff, time3_in;
   logic [lrc_tsp_pkg::STATUS_W-1:0] status3_ff, status3_in;
   logic [CALC_W-1:0]              ms;
   logic [CALC_W-1:0]              upper_ext, field_ext;

   assign adv3      = !v3_ff || rsp_chan.ready;
   assign adv2      = !v2_ff || adv3;
   assign adv1      = !v1_ff || adv2;
   assign rec_ready = adv1;

   assign upper_ext = {{(CALC_W-FIELD_WIDTH){1'b0}}, upper1_ff};
   assign field_ext = {{(CALC_W-FIELD_WIDTH){1'b0}}, field1_ff};
   assign sec2_in   = (upper_ext << 6) - (upper_ext << 2) + field_ext;

   // right-pad the fraction to three digits
   always_comb begin
      case (info1_ff.frac_digits)
         2'd1: frac_wide = ({4'd0, info1_ff.frac_value} << 6) +
                           ({4'd0, info1_ff.frac_value} << 5) +
                           ({4'd0, info1_ff.frac_value} << 2);
         2'd2: frac_wide = ({4'd0, info1_ff.frac_value} << 3) +
                           ({4'd0, info1_ff.frac_value} << 1);
         2'd3: frac_wide = {4'd0, info1_ff.frac_value};
         default: frac_wide = '0;
      endcase
      frac2_in = frac_wide[FW-1:0];
   end

   // x*1000 = x*1024 - x*32 + x*8
   assign ms = (sec2_ff << 10) - (sec2_ff << 5) + (sec2_ff << 3)
             + {{(CALC_W-FW){1'b0}}, frac2_ff};

   always_comb begin
      time3_in   = '0;
      status3_in = lrc_tsp_pkg::STATUS_OK;
      if (bad2_ff) begin
         status3_in = lrc_tsp_pkg::STATUS_MALFORMED;
      end else if (ovf2_ff || ms[CALC_W-1:lrc_tsp_pkg::TIME_W] != '0) begin
         status3_in = lrc_tsp_pkg::STATUS_OVERFLOW;
      end else begin
         time3_in = ms[lrc_tsp_pkg::TIME_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (adv1) begin
            v1_ff <= rec_valid;
         end
         if (adv2) begin
            v2_ff <= v1_ff;
         end
         if (adv3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv1 && rec_valid) begin
         info1_ff  <= rec_info;
         upper1_ff <= rec_upper;
         field1_ff <= rec_field;
      end
      if (adv2 && v1_ff) begin
         bad2_ff  <= info1_ff.bad;
         ovf2_ff  <= info1_ff.overflowed;
         sec2_ff  <= sec2_in;
         frac2_ff <= frac2_in;
      end
      if (adv3 && v2_ff) begin
         time3_ff   <= time3_in;
         status3_ff <= status3_in;
      end
   end

   assign rsp_chan.valid   = v3_ff;
   assign rsp_chan.time_ms = time3_ff;
   assign rsp_chan.status  = status3_ff;

endmodule

/* rtl/lrc_timestamp_tag_parser_top.sv */
// ----------------------------------------------------------------------------
// LRC timestamp tag parser
// Parses [m:s.f] / <m:s.f> timestamp tags from a byte stream into
// milliseconds with malformed and overflow status.
//
//   channel    dir   transaction
//   req_chan   in    one text byte (char_byte) or a line break
//   rsp_chan   out   time_ms and status for each closed tag
//   csr_chan   in    angle_mode write, always ready
//
// One byte per cycle is accepted while req_chan is ready. A closing byte's result
// passes in turn through the capture, seconds-fold and millisecond-scale
// stages before it is valid. Reset clears the mode and any open tag.
// When rsp_chan stalls, the pipeline fills and req_chan drops ready once
// all three stages hold a result.
// ----------------------------------------------------------------------------
module lrc_timestamp_tag_parser_top #(
   parameter int FIELD_WIDTH = lrc_tsp_pkg::FIELD_WIDTH
) (
   input  logic          clock,
   input  logic          reset,
   lrc_tsp_req_if.sink   req_chan,
   lrc_tsp_rsp_if.source rsp_chan,
   lrc_tsp_csr_if.sink   csr_chan
);

   logic                           rec_valid;
   logic                           rec_ready;
   lrc_tsp_pkg::lrc_tsp_close_type rec_info;
   logic [FIELD_WIDTH-1:0]         rec_upper;
   logic [FIELD_WIDTH-1:0]         rec_field;

   lrc_tsp_scanner #(
      .FIELD_WIDTH (FIELD_WIDTH)
   ) u_scanner (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .csr_chan  (csr_chan),
      .rec_ready (rec_ready),
      .rec_valid (rec_valid),
      .rec_info  (rec_info),
      .rec_upper (rec_upper),
      .rec_field (rec_field)
   );

   lrc_tsp_calc #(
      .FIELD_WIDTH (FIELD_WIDTH)
   ) u_calc (
      .clock     (clock),
      .reset     (reset),
      .rec_valid (rec_valid),
      .rec_ready (rec_ready),
      .rec_info  (rec_info),
      .rec_upper (rec_upper),
      .rec_field (rec_field),
      .rsp_chan  (rsp_chan)
   );

endmodule
